// ===== rtl/core/rtu_frame_receiver_defines.svh =====
// Assertion macros for the frame receiver RTL.
`ifndef RTU_FRAME_RECEIVER_DEFINES_SVH
`define RTU_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH
`define RFR_ASSERT_SAME(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |-> (cons)) \
		else $error("frame receiver check failed");
`define RFR_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons) \
	lbl: assert property (@(posedge clk_i) disable iff (!rst_n_i) (ante) |=> (cons)) \
		else $error("frame receiver check failed");
`else
`define RFR_ASSERT_SAME(lbl, clk_i, rst_n_i, ante, cons)
`define RFR_ASSERT_NEXT(lbl, clk_i, rst_n_i, ante, cons)
`endif

`endif

// ===== rtl/core/rfr_pkg.sv =====
// Types, constants and the CRC step of the frame receiver.
package rfr_pkg;

	localparam int STORE_BYTES_DEF = 256;
	localparam int FIFO_DEPTH = 3;
	localparam int HEADER_BYTES = 2;
	localparam int FRAME_OVERHEAD = 4;
	localparam logic [15:0] SILENCE_RESET = 16'd10;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef enum logic [1:0] {
		ACT_BYTE = 2'd0,
		ACT_TICK = 2'd1,
		ACT_READ = 2'd2,
		ACT_NONE = 2'd3
	} rfr_action_t;

	localparam logic KIND_REPORT = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] read_byte;
		logic [7:0] payload_len;
		logic [7:0] function_code;
		logic [7:0] station_addr;
	} rfr_result_t;

	function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/rfr_core.sv =====
// Frame state, byte store and the single result stage of the frame receiver.
module rfr_core #(
	parameter int STORE_BYTES = rfr_pkg::STORE_BYTES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_wdata,
	input  logic                in_accept,
	input  logic [1:0]          action,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         tick_amount,
	input  logic [7:0]          read_index,
	output logic                res_valid,
	output rfr_pkg::rfr_result_t res
);
	import rfr_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);
	localparam int CW = $clog2(STORE_BYTES + 1);
	localparam int PW = $clog2(STORE_BYTES + 258);

	logic [7:0]    store_mem [STORE_BYTES];
	logic [15:0]   silence_ticks_q;
	logic [15:0]   silence_left_q;
	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic [15:0]   last_two_q;
	logic [7:0]    addr_q;
	logic [7:0]    func_q;

	logic          valid_s1;
	logic          kind_s1;
	logic [7:0]    addr_s1;
	logic [7:0]    func_s1;
	logic [7:0]    len_s1;
	logic          in_range_s1;
	logic [7:0]    rd_data_s1;

	rfr_action_t   act;
	logic          store_wr;
	logic          do_read;
	logic          do_tick;
	logic [15:0]   left_next;
	logic          frame_end;
	logic          frame_ok;
	logic [PW-1:0] pos;
	logic          in_range;
	logic [CW-1:0] len_diff;

	always_comb begin
		act = rfr_action_t'(action);
		store_wr = in_accept && (act == ACT_BYTE) && (count_q < CW'(STORE_BYTES));
		do_read = in_accept && (act == ACT_READ);
		do_tick = in_accept && (act == ACT_TICK);
		left_next = (silence_left_q > tick_amount) ? (silence_left_q - tick_amount) : 16'd0;
		frame_end = (left_next == 16'd0) && (count_q != '0);
		frame_ok = (count_q > CW'(FRAME_OVERHEAD)) && (crc_q == last_two_q);
		pos = PW'(read_index) + PW'(HEADER_BYTES);
		in_range = pos < PW'(STORE_BYTES);
		len_diff = count_q - CW'(FRAME_OVERHEAD);
	end

	always_ff @(posedge clk) begin
		if (store_wr) begin
			store_mem[count_q[AW-1:0]] <= rx_byte;
		end
		if (do_read) begin
			rd_data_s1 <= store_mem[pos[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			silence_ticks_q <= SILENCE_RESET;
			silence_left_q <= 16'd0;
			count_q <= '0;
			crc_q <= CRC_INIT;
			last_two_q <= 16'd0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				silence_ticks_q <= cfg_wdata;
			end
			valid_s1 <= do_read || (do_tick && frame_end && frame_ok);
			if (store_wr) begin
				if (count_q >= CW'(HEADER_BYTES)) begin
					crc_q <= crc_fold(crc_q, last_two_q[7:0]);
				end
				last_two_q <= {rx_byte, last_two_q[15:8]};
				count_q <= count_q + CW'(1);
				silence_left_q <= silence_ticks_q;
			end else if (do_tick) begin
				silence_left_q <= left_next;
				if (frame_end) begin
					count_q <= '0;
					crc_q <= CRC_INIT;
					last_two_q <= 16'd0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (store_wr && (count_q == CW'(0))) begin
			addr_q <= rx_byte;
		end
		if (store_wr && (count_q == CW'(1))) begin
			func_q <= rx_byte;
		end
		if (in_accept) begin
			kind_s1 <= (act == ACT_READ) ? KIND_READ : KIND_REPORT;
			addr_s1 <= addr_q;
			func_s1 <= func_q;
			len_s1 <= 8'(len_diff);
			in_range_s1 <= in_range;
		end
	end

	always_comb begin
		res_valid = valid_s1;
		res.kind = kind_s1;
		if (kind_s1 == KIND_READ) begin
			res.station_addr = 8'd0;
			res.function_code = 8'd0;
			res.payload_len = 8'd0;
			res.read_byte = in_range_s1 ? rd_data_s1 : 8'd0;
		end else begin
			res.station_addr = addr_s1;
			res.function_code = func_s1;
			res.payload_len = len_s1;
			res.read_byte = 8'd0;
		end
	end

endmodule

// ===== rtl/core/rfr_out_fifo.sv =====
// Small result queue that decouples the result stage from the output stream.
module rfr_out_fifo (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     push,
	input  rfr_pkg::rfr_result_t                     push_data,
	input  logic                                     pop_ready,
	output logic                                     pop_valid,
	output rfr_pkg::rfr_result_t                     pop_data,
	output logic [$clog2(rfr_pkg::FIFO_DEPTH+1)-1:0] fill
);
	import rfr_pkg::*;

	localparam int PTW = $clog2(FIFO_DEPTH);
	localparam int FW = $clog2(FIFO_DEPTH + 1);

	rfr_result_t    entry_q [FIFO_DEPTH];
	logic [PTW-1:0] wr_ptr_q;
	logic [PTW-1:0] rd_ptr_q;
	logic [FW-1:0]  fill_q;
	logic           pop;

	function automatic logic [PTW-1:0] ptr_inc(input logic [PTW-1:0] p);
		return (p == PTW'(FIFO_DEPTH - 1)) ? '0 : p + PTW'(1);
	endfunction

	always_comb begin
		pop_valid = fill_q != '0;
		pop_data = entry_q[rd_ptr_q];
		pop = pop_valid && pop_ready;
		fill = fill_q;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/rtu_frame_receiver.sv =====
// Top level of the serial frame receiver with silence-based frame end.
//
// Channel   Direction  tuser          tdata (low bits first)
// s_axis    in         action[1:0]    rx_byte, tick_amount, read_index
// m_axis    out        kind           station_addr, function_code, payload_len, read_byte
// cfg       in         -              silence_ticks on cfg_we
//
// An accepted item updates the frame state at once; its result, if any, is ready in the
// next cycle and then passes through a three-entry queue to m_axis.
// One item is taken every cycle while the queue and the result stage hold fewer than
// three results; a stalled m_axis fills the queue and then lowers s_axis_tready.
// Reset clears the frame state and the queue; the byte store keeps no reset value.
`include "rtu_frame_receiver_defines.svh"

module rtu_frame_receiver #(
	parameter int STORE_BYTES = rfr_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // rx_byte, tick_amount, read_index
	input  logic [1:0]  s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // station_addr, function_code, payload_len, read_byte
	output logic        m_axis_tuser   // kind
);
	import rfr_pkg::*;

	localparam int FW = $clog2(FIFO_DEPTH + 1);

	logic          in_accept;
	logic          res_valid;
	rfr_result_t   res;
	rfr_result_t   out_res;
	logic [FW-1:0] fill;
	logic [FW:0]   pending;

	always_comb begin
		pending = {1'b0, fill} + (FW + 1)'(res_valid);
		s_axis_tready = pending < (FW + 1)'(FIFO_DEPTH);
		in_accept = s_axis_tvalid && s_axis_tready;
	end

	rfr_core #(
		.STORE_BYTES(STORE_BYTES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_accept  (in_accept),
		.action     (s_axis_tuser),
		.rx_byte    (s_axis_tdata[7:0]),
		.tick_amount(s_axis_tdata[23:8]),
		.read_index (s_axis_tdata[31:24]),
		.res_valid  (res_valid),
		.res        (res)
	);

	rfr_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (res_valid),
		.push_data(res),
		.pop_ready(m_axis_tready),
		.pop_valid(m_axis_tvalid),
		.pop_data (out_res),
		.fill     (fill)
	);

	assign m_axis_tuser = out_res.kind;
	assign m_axis_tdata = {out_res.read_byte, out_res.payload_len,
		out_res.function_code, out_res.station_addr};

	`RFR_ASSERT_SAME(a_room_for_result, clk, arst_n, res_valid, fill < FW'(FIFO_DEPTH))
	`RFR_ASSERT_NEXT(a_read_gives_result, clk, arst_n,
		in_accept && (s_axis_tuser == ACT_READ), res_valid && (res.kind == KIND_READ))
	`RFR_ASSERT_NEXT(a_byte_no_result, clk, arst_n,
		in_accept && ((s_axis_tuser == ACT_BYTE) || (s_axis_tuser == ACT_NONE)), !res_valid)
	`RFR_ASSERT_SAME(a_report_fields, clk, arst_n,
		res_valid && (res.kind == KIND_REPORT), res.read_byte == 8'd0)

endmodule

// ===== tb/rfr_result_checker.sv =====
// Checker for the frame receiver: predicts every result from the accepted items and compares.
`timescale 1ns / 100ps

module rfr_result_checker #(
	parameter int STORE = rfr_pkg::STORE_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // rx_byte, tick_amount, read_index
	input  logic [1:0]  s_axis_tuser,  // action
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [31:0] m_axis_tdata,  // station_addr, function_code, payload_len, read_byte
	input  logic        m_axis_tuser,  // kind
	output int          fail_count,
	output int          pending,
	output int          reports_seen,
	output int          reads_seen
);
	import rfr_pkg::*;

	logic [7:0]  frame_bytes [STORE];
	int          held;
	logic [15:0] silence_cfg;
	logic [15:0] silence_left;
	logic [15:0] frame_crc;
	logic [15:0] crc_tail;
	rfr_result_t expected_results [$];

	function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		repeat (8) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	task automatic predict_item(input rfr_action_t act, input logic [31:0] data);
		logic [7:0]  rx;
		logic [7:0]  idx;
		logic [15:0] amt;
		rfr_result_t res;
		int          pos;
		rx = data[7:0];
		amt = data[23:8];
		idx = data[31:24];
		res = '0;
		case (act)
			ACT_BYTE: begin
				if (held < STORE) begin
					frame_bytes[held] = rx;
					if (held >= 2) begin
						frame_crc = crc_step(frame_crc, crc_tail[7:0]);
					end
					// The older of the two newest bytes sits in the low half.
					crc_tail = {rx, crc_tail[15:8]};
					held++;
					silence_left = silence_cfg;
				end
			end
			ACT_TICK: begin
				silence_left = (silence_left > amt) ? silence_left - amt : 16'd0;
				if (silence_left == 16'd0 && held > 0) begin
					if (held > FRAME_OVERHEAD && frame_crc == crc_tail) begin
						res.kind = KIND_REPORT;
						res.station_addr = frame_bytes[0];
						res.function_code = frame_bytes[1];
						res.payload_len = 8'(held - FRAME_OVERHEAD);
						expected_results.push_back(res);
					end
					held = 0;
					frame_crc = CRC_INIT;
					crc_tail = 16'h0000;
				end
			end
			ACT_READ: begin
				pos = int'(idx) + HEADER_BYTES;
				res.kind = KIND_READ;
				res.read_byte = (pos < STORE) ? frame_bytes[pos] : 8'h00;
				expected_results.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic check_result(input logic kind, input logic [31:0] data);
		rfr_result_t got;
		rfr_result_t want;
		got.kind = kind;
		got.station_addr = data[7:0];
		got.function_code = data[15:8];
		got.payload_len = data[23:16];
		got.read_byte = data[31:24];
		if (kind == KIND_REPORT) begin
			reports_seen++;
		end else begin
			reads_seen++;
		end
		if (expected_results.size() == 0) begin
			$display("%0t: unexpected result, expected none, got kind %0d addr %02h fn %02h len %0d byte %02h",
				$time, got.kind, got.station_addr, got.function_code, got.payload_len,
				got.read_byte);
			fail_count++;
		end else begin
			want = expected_results.pop_front();
			if (got.kind !== want.kind || got.station_addr !== want.station_addr ||
					got.function_code !== want.function_code ||
					got.payload_len !== want.payload_len || got.read_byte !== want.read_byte) begin
				$display("%0t: result mismatch, expected kind %0d addr %02h fn %02h len %0d byte %02h",
					$time, want.kind, want.station_addr, want.function_code,
					want.payload_len, want.read_byte);
				$display("%0t:                   actual kind %0d addr %02h fn %02h len %0d byte %02h",
					$time, got.kind, got.station_addr, got.function_code, got.payload_len,
					got.read_byte);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held = 0;
			silence_cfg = SILENCE_RESET;
			silence_left = 16'd0;
			frame_crc = CRC_INIT;
			crc_tail = 16'h0000;
			expected_results.delete();
			pending = 0;
			fail_count = 0;
			reports_seen = 0;
			reads_seen = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				check_result(m_axis_tuser, m_axis_tdata);
			end
			if (cfg_we) begin
				silence_cfg = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				predict_item(rfr_action_t'(s_axis_tuser), s_axis_tdata);
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== tb/tb_rtu_frame_receiver.sv =====
// Top of the frame receiver testbench: clock, reset, stimulus, output stalls and verdict.
`timescale 1ns / 100ps

module tb_rtu_frame_receiver;
	import rfr_pkg::*;

	localparam int STORE = STORE_BYTES_DEF;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 258;
	localparam int IDLE_LIMIT = 1000;
	localparam int SETTLE_CYCLES = 6;
	localparam int TAIL_CYCLES = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tuser;

	int fail_count;
	int pending;
	int reports_seen;
	int reads_seen;

	int          next_gap = 0;
	bit          valid_held = 1'b0;
	bit          steady = 1'b0;
	int          run_bytes = 0;
	int          store_extent = 0;
	int          items_sent = 0;
	int          bytes_sent = 0;
	int          ticks_sent = 0;
	int          reads_sent = 0;
	int          settings_used = 1;
	int          idle_cycles = 0;
	logic [15:0] silence_now = SILENCE_RESET;

	rtu_frame_receiver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	rfr_result_checker #(.STORE(STORE)) i_chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending),
		.reports_seen  (reports_seen),
		.reads_seen    (reads_seen)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no item moved for %0d cycles.", IDLE_LIMIT);
			$display("tb_rtu_frame_receiver: done, errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic int draw_gap();
		if (steady || $urandom_range(0, 2) == 0) begin
			return 0;
		end
		return $urandom_range(0, 18);
	endfunction

	// Only entries written since reset may be read back, so offsets stay below the
	// longest run of bytes seen without a tick, apart from offsets past the store.
	function automatic logic [7:0] pick_read_index();
		if (store_extent < 3 || $urandom_range(0, 9) == 0) begin
			return 8'($urandom_range(STORE - HEADER_BYTES, 255));
		end
		return 8'($urandom_range(0, store_extent - 3));
	endfunction

	task automatic send_item(input rfr_action_t act, input logic [7:0] rx, input logic [15:0] amt,
			input logic [7:0] idx);
		repeat (next_gap) @(posedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {idx, amt, rx};
		do @(posedge clk); while (!s_axis_tready);
		case (act)
			ACT_BYTE: begin
				bytes_sent++;
				if (run_bytes < STORE) begin
					run_bytes++;
				end
				if (run_bytes > store_extent) begin
					store_extent = run_bytes;
				end
			end
			ACT_TICK: begin
				ticks_sent++;
				run_bytes = 0;
			end
			ACT_READ: begin
				reads_sent++;
			end
			default: begin
			end
		endcase
		if (act != ACT_NONE) begin
			items_sent++;
		end
		next_gap = draw_gap();
		if (next_gap > 0) begin
			s_axis_tvalid <= 1'b0;
			valid_held = 1'b0;
		end else begin
			valid_held = 1'b1;
		end
	endtask

	task automatic hold_off();
		if (valid_held) begin
			s_axis_tvalid <= 1'b0;
			valid_held = 1'b0;
		end
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item(ACT_BYTE, b, 16'($urandom), 8'($urandom));
	endtask

	task automatic send_tick(input logic [15:0] amt);
		send_item(ACT_TICK, 8'($urandom), amt, 8'($urandom));
	endtask

	task automatic send_read(input logic [7:0] idx);
		send_item(ACT_READ, 8'($urandom), 16'($urandom), idx);
	endtask

	// A frame carries its CRC in the last two stored bytes, low byte first; bytes past
	// the store are extra and never counted by the receiver.
	task automatic send_frame(input int len, input bit corrupt, input logic [7:0] addr,
			input logic [7:0] func);
		logic [7:0]  body [320];
		logic [15:0] crc;
		int          stored;
		int          k;
		int          left;
		int          amt;
		stored = (len < STORE) ? len : STORE;
		for (k = 0; k < len; k++) begin
			body[k] = 8'($urandom);
		end
		body[0] = addr;
		body[1] = func;
		if (stored >= 2) begin
			crc = CRC_INIT;
			for (k = 0; k < stored - 2; k++) begin
				crc = crc ^ {8'h00, body[k]};
				repeat (8) begin
					crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
				end
			end
			body[stored - 2] = crc[7:0];
			body[stored - 1] = crc[15:8];
		end
		if (corrupt) begin
			k = $urandom_range(0, stored - 1);
			body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
		end
		if (run_bytes > 0 && $urandom_range(0, 3) != 0) begin
			send_tick(16'hFFFF);
		end
		for (k = 0; k < len; k++) begin
			send_byte(body[k]);
			if (k < len - 1 && k < STORE - 1) begin
				if (silence_now >= 2 && $urandom_range(0, 5) == 0) begin
					send_tick(16'($urandom_range(0, silence_now - 1)));
				end
				if ($urandom_range(0, 11) == 0) begin
					send_read(pick_read_index());
				end
			end
		end
		if (silence_now >= 2 && silence_now <= 64 && $urandom_range(0, 2) == 0) begin
			left = silence_now;
			while (left > 0) begin
				amt = $urandom_range(1, silence_now / 2);
				send_tick(16'(amt));
				left = (left > amt) ? left - amt : 0;
			end
		end else begin
			send_tick(16'($urandom_range(silence_now, 65535)));
		end
	endtask

	task automatic set_silence(input logic [15:0] value);
		hold_off();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		silence_now = value;
		settings_used++;
	endtask

	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = draw_gap();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (m_axis_tvalid !== 1'b1);
		end
	end

	initial begin
		logic [15:0] plan [PHASES];
		int          ph;
		int          phase_start;
		int          r;
		int          q;
		int          len;
		rfr_action_t act;
		plan = '{SILENCE_RESET, 16'd1, 16'hFFFF, 16'd0, 16'd0, 16'd10};
		plan[4] = 16'($urandom_range(2, 300));
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 16'h0000;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= 32'h0;
		s_axis_tuser <= ACT_NONE;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (ph = 0; ph < PHASES; ph++) begin
			if (ph > 0) begin
				set_silence(plan[ph]);
			end
			phase_start = items_sent;
			if (ph == 0) begin
				send_tick(16'h0000);
				send_tick(16'hFFFF);
				send_read(8'hFF);
				send_read(8'hFE);
				send_item(ACT_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
				send_frame(5, 1'b0, 8'h00, 8'hFF);
				send_read(8'h00);
				send_frame(5, 1'b0, 8'hFF, 8'h00);
				send_frame(4, 1'b0, 8'($urandom), 8'($urandom));
				send_frame(1, 1'b0, 8'($urandom), 8'($urandom));
				send_frame(7, 1'b1, 8'($urandom), 8'($urandom));
				send_read(8'h02);
			end
			if (ph == 2) begin
				// Fills the store and overruns it; the payload length comes out at its top value.
				send_frame(STORE + $urandom_range(1, 6), 1'b0, 8'($urandom), 8'($urandom));
				send_read(8'(STORE - HEADER_BYTES - 1));
				send_read(8'h00);
			end
			while (items_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 68) begin
					steady = ($urandom_range(0, 9) == 0);
					q = $urandom_range(0, 19);
					if (q < 17) begin
						len = $urandom_range(5, 12);
					end else if (q < 19) begin
						len = $urandom_range(1, 4);
					end else begin
						len = $urandom_range(13, 40);
					end
					send_frame(len, $urandom_range(0, 5) == 0, 8'($urandom), 8'($urandom));
				end else if (r < 84) begin
					send_read(pick_read_index());
				end else if (r < 96) begin
					act = rfr_action_t'($urandom_range(0, 1));
					send_item(act, 8'($urandom), 16'($urandom), 8'($urandom));
				end else begin
					send_item(ACT_NONE, 8'($urandom), 16'($urandom), 8'($urandom));
				end
			end
		end

		hold_off();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Run covered %0d items (%0d bytes, %0d ticks, %0d reads) under %0d silence settings.",
			items_sent, bytes_sent, ticks_sent, reads_sent, settings_used);
		$display("Checked %0d frame reports and %0d read replies, %0d mismatching.",
			reports_seen, reads_seen, fail_count);
		if (fail_count == 0) begin
			$display("tb_rtu_frame_receiver: done, clean");
		end else begin
			$display("tb_rtu_frame_receiver: done, errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/rfr_pkg.sv
rtl/core/rfr_core.sv
rtl/core/rfr_out_fifo.sv
rtl/core/rtu_frame_receiver.sv
tb/rfr_result_checker.sv
tb/tb_rtu_frame_receiver.sv
